// ===== rtl/crgd_pkg.sv =====
// Package for the clipped rectangle and glyph draw unit.
// Frame geometry, field widths, opcodes and the 5x7 glyph table.
// No dependencies; imported by clipped_rect_and_glyph_draw_unit.
`timescale 1ns / 1ps

package crgd_pkg;

    // Frame geometry
    localparam int FRAME_WIDTH  = 128;
    localparam int FRAME_HEIGHT = 64;
    localparam int STORE_WORDS  = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int COL_W        = $clog2(FRAME_WIDTH);
    localparam int ROW_W        = $clog2(FRAME_HEIGHT);
    localparam int ADDR_W       = $clog2(STORE_WORDS);

    // Field widths
    localparam int OP_W      = 2;
    localparam int COORD_W   = 16;
    localparam int COLOR_W   = 32;
    localparam int CODE_W    = 8;
    localparam int COUNT_W   = 14;
    localparam int S_TDATA_W = 104;  // 4 x 16 + 32 + 8
    localparam int M_TDATA_W = 48;   // 32 + 14, padded to whole bytes

    // Signed width for clipping math, never overflows for 16-bit inputs
    localparam int CALC_W = 18;

    // Glyph cell
    localparam int GLYPH_COLS  = 5;
    localparam int GLYPH_ROWS  = 7;
    localparam int GCOL_IDX_W  = $clog2(GLYPH_COLS);
    localparam int GROW_IDX_W  = 3;
    localparam int GLYPH_CNT   = 95;
    localparam int GLYPH_IDX_W = $clog2(GLYPH_CNT);

    localparam logic [CODE_W-1:0] FIRST_CODE = CODE_W'(32);
    localparam logic [CODE_W-1:0] LAST_CODE  = CODE_W'(126);

    localparam logic signed [CALC_W-1:0] FW_S      = CALC_W'(FRAME_WIDTH);
    localparam logic signed [CALC_W-1:0] FH_S      = CALC_W'(FRAME_HEIGHT);
    localparam logic signed [CALC_W-1:0] GLYPH_W_S = CALC_W'(GLYPH_COLS);
    localparam logic signed [CALC_W-1:0] GLYPH_H_S = CALC_W'(GLYPH_ROWS);

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_FILL  = 2'd0,
        OP_GLYPH = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef logic [GLYPH_COLS-1:0][7:0] glyph_t;

    // Pack five column bytes, leftmost column in the lowest byte
    function automatic glyph_t pack5(input logic [7:0] c0, input logic [7:0] c1,
                                     input logic [7:0] c2, input logic [7:0] c3,
                                     input logic [7:0] c4);
        pack5 = {c4, c3, c2, c1, c0};
    endfunction

    // Glyph table, indexed by code minus the first printable code.
    // Bit r of a column byte is row r from the top.
    function automatic glyph_t glyph_bits(input logic [GLYPH_IDX_W-1:0] idx);
        case (idx)
            7'd1:  glyph_bits = pack5(8'h00, 8'h7F, 8'h00, 8'h00, 8'h00);
            7'd2:  glyph_bits = pack5(8'h00, 8'h7F, 8'h00, 8'h00, 8'h00);
            7'd3:  glyph_bits = pack5(8'h21, 8'h7F, 8'h21, 8'h7F, 8'h21);
            7'd4:  glyph_bits = pack5(8'h14, 8'h7F, 8'h7F, 8'h14, 8'h7F);
            7'd5:  glyph_bits = pack5(8'h24, 8'h2A, 8'h7F, 8'h2A, 8'h12);
            7'd6:  glyph_bits = pack5(8'h23, 8'h13, 8'h08, 8'h64, 8'h62);
            7'd7:  glyph_bits = pack5(8'h36, 8'h49, 8'h55, 8'h22, 8'h50);
            7'd8:  glyph_bits = pack5(8'h00, 8'h05, 8'h03, 8'h00, 8'h00);
            7'd9:  glyph_bits = pack5(8'h00, 8'h1C, 8'h22, 8'h41, 8'h00);
            7'd10: glyph_bits = pack5(8'h14, 8'h7F, 8'h41, 8'h7F, 8'h14);
            7'd11: glyph_bits = pack5(8'h08, 8'h3E, 8'h41, 8'h3E, 8'h08);
            7'd12: glyph_bits = pack5(8'h00, 8'h08, 8'h08, 8'h00, 8'h00);
            7'd13: glyph_bits = pack5(8'h08, 8'h08, 8'h3E, 8'h08, 8'h08);
            7'd14: glyph_bits = pack5(8'h00, 8'hA0, 8'h60, 8'h00, 8'h00);
            7'd15: glyph_bits = pack5(8'h08, 8'h08, 8'h08, 8'h08, 8'h08);
            7'd16: glyph_bits = pack5(8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E);
            7'd17: glyph_bits = pack5(8'h00, 8'h42, 8'h7F, 8'h40, 8'h00);
            7'd18: glyph_bits = pack5(8'h42, 8'h61, 8'h51, 8'h49, 8'h46);
            7'd19: glyph_bits = pack5(8'h21, 8'h45, 8'h4B, 8'h4D, 8'h33);
            7'd20: glyph_bits = pack5(8'h18, 8'h14, 8'h12, 8'h7F, 8'h10);
            7'd21: glyph_bits = pack5(8'h27, 8'h45, 8'h45, 8'h45, 8'h39);
            7'd22: glyph_bits = pack5(8'h3C, 8'h4A, 8'h49, 8'h48, 8'h30);
            7'd23: glyph_bits = pack5(8'h01, 8'h71, 8'h09, 8'h05, 8'h03);
            7'd24: glyph_bits = pack5(8'h36, 8'h49, 8'h49, 8'h49, 8'h36);
            7'd25: glyph_bits = pack5(8'h06, 8'h49, 8'h49, 8'h29, 8'h1E);
            7'd26: glyph_bits = pack5(8'h00, 8'h36, 8'h36, 8'h00, 8'h00);
            7'd27: glyph_bits = pack5(8'h00, 8'h41, 8'h36, 8'h08, 8'h00);
            7'd28: glyph_bits = pack5(8'h08, 8'h14, 8'h14, 8'h08, 8'h3E);
            7'd29: glyph_bits = pack5(8'h08, 8'h14, 8'h22, 8'h22, 8'h3E);
            7'd30: glyph_bits = pack5(8'h3E, 8'h08, 8'h14, 8'h22, 8'h3E);
            7'd31: glyph_bits = pack5(8'h46, 8'h29, 8'h19, 8'h09, 8'h07);
            7'd32: glyph_bits = pack5(8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E);
            7'd33: glyph_bits = pack5(8'h7F, 8'h41, 8'h41, 8'h41, 8'h3E);
            7'd34: glyph_bits = pack5(8'h7F, 8'h49, 8'h49, 8'h49, 8'h41);
            7'd35: glyph_bits = pack5(8'h7F, 8'h09, 8'h09, 8'h09, 8'h01);
            7'd36: glyph_bits = pack5(8'h3E, 8'h41, 8'h49, 8'h49, 8'h3A);
            7'd37: glyph_bits = pack5(8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F);
            7'd38: glyph_bits = pack5(8'h00, 8'h41, 8'h7F, 8'h41, 8'h00);
            7'd39: glyph_bits = pack5(8'h20, 8'h40, 8'h41, 8'h3F, 8'h01);
            7'd40: glyph_bits = pack5(8'h7F, 8'h08, 8'h14, 8'h22, 8'h41);
            7'd41: glyph_bits = pack5(8'h7F, 8'h40, 8'h40, 8'h40, 8'h40);
            7'd42: glyph_bits = pack5(8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F);
            7'd43: glyph_bits = pack5(8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F);
            7'd44: glyph_bits = pack5(8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E);
            7'd45: glyph_bits = pack5(8'h7F, 8'h09, 8'h09, 8'h09, 8'h06);
            7'd46: glyph_bits = pack5(8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E);
            7'd47: glyph_bits = pack5(8'h7F, 8'h09, 8'h19, 8'h29, 8'h46);
            7'd48: glyph_bits = pack5(8'h26, 8'h49, 8'h49, 8'h49, 8'h32);
            7'd49: glyph_bits = pack5(8'h01, 8'h01, 8'h7F, 8'h01, 8'h01);
            7'd50: glyph_bits = pack5(8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F);
            7'd51: glyph_bits = pack5(8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F);
            7'd52: glyph_bits = pack5(8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F);
            7'd53: glyph_bits = pack5(8'h63, 8'h14, 8'h08, 8'h14, 8'h63);
            7'd54: glyph_bits = pack5(8'h07, 8'h08, 8'h70, 8'h08, 8'h07);
            7'd55: glyph_bits = pack5(8'h61, 8'h51, 8'h49, 8'h45, 8'h43);
            7'd56: glyph_bits = pack5(8'h00, 8'h7F, 8'h41, 8'h41, 8'h00);
            7'd57: glyph_bits = pack5(8'h02, 8'h04, 8'h08, 8'h10, 8'h20);
            7'd58: glyph_bits = pack5(8'h00, 8'h41, 8'h41, 8'h7F, 8'h00);
            7'd59: glyph_bits = pack5(8'h04, 8'h02, 8'h01, 8'h02, 8'h04);
            7'd60: glyph_bits = pack5(8'h40, 8'h40, 8'h40, 8'h40, 8'h40);
            7'd61: glyph_bits = pack5(8'h00, 8'h01, 8'h02, 8'h04, 8'h00);
            7'd62: glyph_bits = pack5(8'h20, 8'h54, 8'h54, 8'h54, 8'h78);
            7'd63: glyph_bits = pack5(8'h7F, 8'h48, 8'h44, 8'h44, 8'h38);
            7'd64: glyph_bits = pack5(8'h38, 8'h44, 8'h44, 8'h44, 8'h20);
            7'd65: glyph_bits = pack5(8'h38, 8'h44, 8'h44, 8'h48, 8'h7F);
            7'd66: glyph_bits = pack5(8'h38, 8'h54, 8'h54, 8'h54, 8'h18);
            7'd67: glyph_bits = pack5(8'h08, 8'h7E, 8'h09, 8'h01, 8'h02);
            7'd68: glyph_bits = pack5(8'h0C, 8'h52, 8'h52, 8'h52, 8'h3E);
            7'd69: glyph_bits = pack5(8'h7F, 8'h08, 8'h04, 8'h04, 8'h78);
            7'd70: glyph_bits = pack5(8'h00, 8'h44, 8'h7D, 8'h40, 8'h00);
            7'd71: glyph_bits = pack5(8'h20, 8'h40, 8'h44, 8'h3D, 8'h08);
            7'd72: glyph_bits = pack5(8'h7F, 8'h10, 8'h28, 8'h44, 8'h00);
            7'd73: glyph_bits = pack5(8'h00, 8'h41, 8'h7F, 8'h40, 8'h00);
            7'd74: glyph_bits = pack5(8'h7C, 8'h04, 8'h18, 8'h04, 8'h78);
            7'd75: glyph_bits = pack5(8'h7C, 8'h08, 8'h04, 8'h04, 8'h78);
            7'd76: glyph_bits = pack5(8'h38, 8'h44, 8'h44, 8'h44, 8'h38);
            7'd77: glyph_bits = pack5(8'hFC, 8'h24, 8'h24, 8'h24, 8'h18);
            7'd78: glyph_bits = pack5(8'h18, 8'h24, 8'h24, 8'h18, 8'hFC);
            7'd79: glyph_bits = pack5(8'h7C, 8'h08, 8'h04, 8'h04, 8'h08);
            7'd80: glyph_bits = pack5(8'h48, 8'h54, 8'h54, 8'h54, 8'h20);
            7'd81: glyph_bits = pack5(8'h04, 8'h3F, 8'h44, 8'h40, 8'h20);
            7'd82: glyph_bits = pack5(8'h3C, 8'h40, 8'h40, 8'h20, 8'h7C);
            7'd83: glyph_bits = pack5(8'h1C, 8'h20, 8'h40, 8'h20, 8'h1C);
            7'd84: glyph_bits = pack5(8'h3C, 8'h40, 8'h30, 8'h40, 8'h3C);
            7'd85: glyph_bits = pack5(8'h44, 8'h28, 8'h10, 8'h28, 8'h44);
            7'd86: glyph_bits = pack5(8'h0C, 8'h50, 8'h50, 8'h50, 8'h3E);
            7'd87: glyph_bits = pack5(8'h44, 8'h64, 8'h54, 8'h4C, 8'h44);
            7'd88: glyph_bits = pack5(8'h08, 8'h08, 8'h2A, 8'h1C, 8'h08);
            // space, the blank tail of the table and unused indexes
            default: glyph_bits = '0;
        endcase
    endfunction

endpackage

// ===== rtl/clipped_rect_and_glyph_draw_unit.sv =====
// Clipped rectangle fill, 5x7 glyph draw and pixel read over an on-chip frame store.
// Depends on crgd_pkg (geometry, widths, opcodes, glyph table).
`timescale 1ns / 1ps

// The unit owns a FRAME_WIDTH x FRAME_HEIGHT store of 32-bit colors, row-major, in one
// synchronous RAM with a write port and a registered read port; its contents are undefined
// until written. Every input transfer yields exactly one output transfer. A fill visits
// each pixel of the clipped w x h rectangle (none when nothing is left after clipping),
// a glyph all 35 pixel slots of its cell, writing only set bits, unless refused. The
// single write port, one pixel per cycle, sets the drawing time. A new item is taken
// while a finished result still waits in the output register.
module clipped_rect_and_glyph_draw_unit import crgd_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata from bit 0: x_pos[16], y_pos[16], rect_width[16], rect_height[16],
    // color[32], char_code[8]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser: op[2]
    input  logic [OP_W-1:0]      s_tuser,
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata from bit 0: read_value[32], pixels_written[14], zero pad[2]
    output logic [M_TDATA_W-1:0] m_tdata,
    // m_tuser: rejected[1]
    output logic                 m_tuser
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CLIP,
        ST_SETUP,
        ST_DRAW,
        ST_RDATA,
        ST_FINISH
    } state_t;

    state_t state_reg;

    // captured item
    op_t                       op_reg;
    logic signed [COORD_W-1:0] x_reg, y_reg, w_reg, h_reg;
    logic [COLOR_W-1:0]        color_reg;
    logic [CODE_W-1:0]         code_reg;

    // clipped rectangle
    logic signed [CALC_W-1:0]  xc_reg, yc_reg, wc_reg, hc_reg;

    // drawing walker
    logic                      glyph_mode_reg;
    glyph_t                    glyph_reg;
    logic [COL_W-1:0]          col_cnt_reg, col_last_reg;
    logic [ROW_W-1:0]          row_cnt_reg, row_last_reg;
    logic [ADDR_W-1:0]         addr_reg, row_start_reg;

    // result
    logic [COUNT_W-1:0]        cnt_reg;
    logic                      rej_reg;
    logic [COLOR_W-1:0]        value_reg;
    logic                      m_tvalid_reg;
    logic [COLOR_W-1:0]        out_value_reg;
    logic [COUNT_W-1:0]        out_count_reg;
    logic                      out_rej_reg;

    // frame store
    logic [COLOR_W-1:0]        frame_mem [STORE_WORDS];
    logic [COLOR_W-1:0]        rd_data_reg;

    logic signed [CALC_W-1:0]  x_ext, y_ext, w_ext, h_ext;
    logic signed [CALC_W-1:0]  x_lft, y_lft, w_lft, h_lft;
    logic signed [CALC_W-1:0]  w_cut, h_cut;
    logic                      code_ok, glyph_off, read_off, rect_empty;
    logic [ADDR_W-1:0]         pix_addr, rect_addr, next_row;
    logic                      pix_on, row_end, last_pix;
    logic                      mem_we, mem_re;

    // input handshake
    assign s_tready = (state_reg == ST_IDLE);

    // output channel
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - COLOR_W - COUNT_W){1'b0}}, out_count_reg, out_value_reg};
    assign m_tuser  = out_rej_reg;

    // sign-extended coordinates
    assign x_ext = CALC_W'(x_reg);
    assign y_ext = CALC_W'(y_reg);
    assign w_ext = CALC_W'(w_reg);
    assign h_ext = CALC_W'(h_reg);

    // range checks for glyph and read
    assign code_ok   = (code_reg >= FIRST_CODE) && (code_reg <= LAST_CODE);
    assign glyph_off = x_ext[CALC_W-1] || y_ext[CALC_W-1] ||
                       (x_ext + GLYPH_W_S > FW_S) || (y_ext + GLYPH_H_S > FH_S);
    assign read_off  = x_ext[CALC_W-1] || y_ext[CALC_W-1] ||
                       (x_ext >= FW_S) || (y_ext >= FH_S);
    assign pix_addr  = ADDR_W'(y_reg[ROW_W-1:0]) * ADDR_W'(FRAME_WIDTH) +
                       ADDR_W'(x_reg[COL_W-1:0]);

    // left and top clipping
    assign x_lft = x_ext[CALC_W-1] ? '0 : x_ext;
    assign w_lft = x_ext[CALC_W-1] ? (w_ext + x_ext) : w_ext;
    assign y_lft = y_ext[CALC_W-1] ? '0 : y_ext;
    assign h_lft = y_ext[CALC_W-1] ? (h_ext + y_ext) : h_ext;

    // right and bottom clipping
    assign w_cut = (xc_reg + wc_reg > FW_S) ? (FW_S - xc_reg) : wc_reg;
    assign h_cut = (yc_reg + hc_reg > FH_S) ? (FH_S - yc_reg) : hc_reg;

    assign rect_empty = (wc_reg <= 0) || (hc_reg <= 0);
    assign rect_addr  = ADDR_W'(yc_reg[ROW_W-1:0]) * ADDR_W'(FRAME_WIDTH) +
                        ADDR_W'(xc_reg[COL_W-1:0]);

    // walker
    assign pix_on   = glyph_mode_reg ?
                      glyph_reg[col_cnt_reg[GCOL_IDX_W-1:0]][row_cnt_reg[GROW_IDX_W-1:0]] :
                      1'b1;
    assign row_end  = (col_cnt_reg == col_last_reg);
    assign last_pix = row_end && (row_cnt_reg == row_last_reg);
    assign next_row = row_start_reg + ADDR_W'(FRAME_WIDTH);

    assign mem_we = (state_reg == ST_DRAW) && pix_on;
    assign mem_re = (state_reg == ST_DECODE) && (op_reg == OP_READ) && !read_off;

    // frame store ports
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            frame_mem[addr_reg] <= color_reg;
        end
        if (mem_re) begin
            rd_data_reg <= frame_mem[pix_addr];
        end
    end

    // sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            // drained output register; a finishing item refills it below
            if (m_tvalid_reg && m_tready && state_reg != ST_FINISH) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        op_reg    <= op_t'(s_tuser);
                        x_reg     <= s_tdata[15:0];
                        y_reg     <= s_tdata[31:16];
                        w_reg     <= s_tdata[47:32];
                        h_reg     <= s_tdata[63:48];
                        color_reg <= s_tdata[95:64];
                        code_reg  <= s_tdata[103:96];
                        state_reg <= ST_DECODE;
                    end
                end

                ST_DECODE: begin
                    cnt_reg        <= '0;
                    rej_reg        <= 1'b0;
                    value_reg      <= '0;
                    glyph_mode_reg <= 1'b0;
                    unique case (op_reg)
                        OP_FILL: begin
                            xc_reg    <= x_lft;
                            wc_reg    <= w_lft;
                            yc_reg    <= y_lft;
                            hc_reg    <= h_lft;
                            state_reg <= ST_CLIP;
                        end
                        OP_GLYPH: begin
                            if (!code_ok || glyph_off) begin
                                rej_reg   <= 1'b1;
                                state_reg <= ST_FINISH;
                            end else begin
                                glyph_reg      <= glyph_bits(GLYPH_IDX_W'(code_reg - FIRST_CODE));
                                glyph_mode_reg <= 1'b1;
                                col_cnt_reg    <= '0;
                                row_cnt_reg    <= '0;
                                col_last_reg   <= COL_W'(GLYPH_COLS - 1);
                                row_last_reg   <= ROW_W'(GLYPH_ROWS - 1);
                                addr_reg       <= pix_addr;
                                row_start_reg  <= pix_addr;
                                state_reg      <= ST_DRAW;
                            end
                        end
                        OP_READ: begin
                            if (read_off) begin
                                rej_reg   <= 1'b1;
                                state_reg <= ST_FINISH;
                            end else begin
                                state_reg <= ST_RDATA;
                            end
                        end
                        OP_NONE: begin
                            state_reg <= ST_FINISH;
                        end
                    endcase
                end

                ST_CLIP: begin
                    wc_reg    <= w_cut;
                    hc_reg    <= h_cut;
                    state_reg <= ST_SETUP;
                end

                ST_SETUP: begin
                    if (rect_empty) begin
                        state_reg <= ST_FINISH;
                    end else begin
                        col_cnt_reg   <= '0;
                        row_cnt_reg   <= '0;
                        col_last_reg  <= COL_W'(wc_reg - CALC_W'(1));
                        row_last_reg  <= ROW_W'(hc_reg - CALC_W'(1));
                        addr_reg      <= rect_addr;
                        row_start_reg <= rect_addr;
                        state_reg     <= ST_DRAW;
                    end
                end

                // one pixel slot per cycle, row by row
                ST_DRAW: begin
                    if (pix_on) begin
                        cnt_reg <= cnt_reg + COUNT_W'(1);
                    end
                    if (row_end) begin
                        col_cnt_reg <= '0;
                        if (last_pix) begin
                            state_reg <= ST_FINISH;
                        end else begin
                            row_cnt_reg   <= row_cnt_reg + ROW_W'(1);
                            row_start_reg <= next_row;
                            addr_reg      <= next_row;
                        end
                    end else begin
                        col_cnt_reg <= col_cnt_reg + COL_W'(1);
                        addr_reg    <= addr_reg + ADDR_W'(1);
                    end
                end

                ST_RDATA: begin
                    value_reg <= rd_data_reg;
                    state_reg <= ST_FINISH;
                end

                // hand the result to the output register once it is free
                ST_FINISH: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg  <= 1'b1;
                        out_value_reg <= value_reg;
                        out_count_reg <= cnt_reg;
                        out_rej_reg   <= rej_reg;
                        state_reg     <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // walker never leaves the frame store
    a_addr_in_store: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAW) |->
        ((ADDR_W+1)'(addr_reg) < (ADDR_W+1)'(STORE_WORDS)))
        else $error("draw address beyond frame store");

    // a glyph never counts more than its cell
    a_glyph_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAW && glyph_mode_reg) |->
        (cnt_reg < COUNT_W'(GLYPH_COLS * GLYPH_ROWS)))
        else $error("glyph pixel count overrun");

    // read data is picked up in the cycle after the read is issued
    a_read_followed: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_re |=> (state_reg == ST_RDATA))
        else $error("read issued without data pickup");

    // a finished result lands in the output register when it is free
    a_finish_hands_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && (!m_tvalid_reg || m_tready)) |=>
        (m_tvalid_reg && state_reg == ST_IDLE))
        else $error("result not handed to output register");
`endif

endmodule

// ===== test/clipped_rect_and_glyph_draw_unit_tb.sv =====
// Testbench for clipped_rect_and_glyph_draw_unit: fill, glyph, read and unused ops.
// A local frame-store predictor computes every result; streaming checks run in order.
// Depends on crgd_pkg and the clipped_rect_and_glyph_draw_unit RTL only.
`timescale 1ns / 1ps

module clipped_rect_and_glyph_draw_unit_tb import crgd_pkg::*; ();

    // One draw command as carried on the input channel
    typedef struct packed {
        op_t                op;
        logic signed [15:0] x_pos;
        logic signed [15:0] y_pos;
        logic signed [15:0] rect_width;
        logic signed [15:0] rect_height;
        logic [31:0]        color;
        logic [7:0]         char_code;
    } draw_cmd_t;

    // One result as carried on the output channel
    typedef struct packed {
        logic [31:0] read_value;
        logic [13:0] pixels_written;
        logic        rejected;
    } draw_result_t;

    // Receiver stall patterns
    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_BURSTY
    } ready_pattern_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;    // x_pos, y_pos, rect_width, rect_height, color, char_code
    logic [OP_W-1:0]      s_tuser;    // op
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;    // read_value, pixels_written, zero pad
    logic                 m_tuser;    // rejected

    // Predictor state: colors and which pixels have been written since reset
    logic [31:0]  frame_colors [STORE_WORDS];
    bit           frame_written [STORE_WORDS];
    draw_result_t pending_draw_results [$];

    int  mismatch_count = 0;
    int  burst_left     = 0;
    bit  sender_gaps_on = 1'b1;
    int  hold_off_left  = 0;

    clipped_rect_and_glyph_draw_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock, 2 ns period
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #4_000_000;
        $display("clipped_rect_and_glyph_draw_unit test failed");
        $finish;
    end

    // 5x7 font, column bytes left to right (leftmost in the top byte), bit r = row r
    function automatic logic [39:0] glyph_columns(input int idx);
        case (idx)
            1:  glyph_columns = 40'h007F000000;  2:  glyph_columns = 40'h007F000000;
            3:  glyph_columns = 40'h217F217F21;  4:  glyph_columns = 40'h147F7F147F;
            5:  glyph_columns = 40'h242A7F2A12;  6:  glyph_columns = 40'h2313086462;
            7:  glyph_columns = 40'h3649552250;  8:  glyph_columns = 40'h0005030000;
            9:  glyph_columns = 40'h001C224100;  10: glyph_columns = 40'h147F417F14;
            11: glyph_columns = 40'h083E413E08;  12: glyph_columns = 40'h0008080000;
            13: glyph_columns = 40'h08083E0808;  14: glyph_columns = 40'h00A0600000;
            15: glyph_columns = 40'h0808080808;  16: glyph_columns = 40'h3E5149453E;
            17: glyph_columns = 40'h00427F4000;  18: glyph_columns = 40'h4261514946;
            19: glyph_columns = 40'h21454B4D33;  20: glyph_columns = 40'h1814127F10;
            21: glyph_columns = 40'h2745454539;  22: glyph_columns = 40'h3C4A494830;
            23: glyph_columns = 40'h0171090503;  24: glyph_columns = 40'h3649494936;
            25: glyph_columns = 40'h064949291E;  26: glyph_columns = 40'h0036360000;
            27: glyph_columns = 40'h0041360800;  28: glyph_columns = 40'h081414083E;
            29: glyph_columns = 40'h081422223E;  30: glyph_columns = 40'h3E0814223E;
            31: glyph_columns = 40'h4629190907;  32: glyph_columns = 40'h3E4141413E;
            33: glyph_columns = 40'h7F4141413E;  34: glyph_columns = 40'h7F49494941;
            35: glyph_columns = 40'h7F09090901;  36: glyph_columns = 40'h3E4149493A;
            37: glyph_columns = 40'h7F0808087F;  38: glyph_columns = 40'h00417F4100;
            39: glyph_columns = 40'h2040413F01;  40: glyph_columns = 40'h7F08142241;
            41: glyph_columns = 40'h7F40404040;  42: glyph_columns = 40'h7F020C027F;
            43: glyph_columns = 40'h7F0408107F;  44: glyph_columns = 40'h3E4141413E;
            45: glyph_columns = 40'h7F09090906;  46: glyph_columns = 40'h3E4151215E;
            47: glyph_columns = 40'h7F09192946;  48: glyph_columns = 40'h2649494932;
            49: glyph_columns = 40'h01017F0101;  50: glyph_columns = 40'h3F4040403F;
            51: glyph_columns = 40'h1F2040201F;  52: glyph_columns = 40'h3F4038403F;
            53: glyph_columns = 40'h6314081463;  54: glyph_columns = 40'h0708700807;
            55: glyph_columns = 40'h6151494543;  56: glyph_columns = 40'h007F414100;
            57: glyph_columns = 40'h0204081020;  58: glyph_columns = 40'h0041417F00;
            59: glyph_columns = 40'h0402010204;  60: glyph_columns = 40'h4040404040;
            61: glyph_columns = 40'h0001020400;  62: glyph_columns = 40'h2054545478;
            63: glyph_columns = 40'h7F48444438;  64: glyph_columns = 40'h3844444420;
            65: glyph_columns = 40'h384444487F;  66: glyph_columns = 40'h3854545418;
            67: glyph_columns = 40'h087E090102;  68: glyph_columns = 40'h0C5252523E;
            69: glyph_columns = 40'h7F08040478;  70: glyph_columns = 40'h00447D4000;
            71: glyph_columns = 40'h2040443D08;  72: glyph_columns = 40'h7F10284400;
            73: glyph_columns = 40'h00417F4000;  74: glyph_columns = 40'h7C04180478;
            75: glyph_columns = 40'h7C08040478;  76: glyph_columns = 40'h3844444438;
            77: glyph_columns = 40'hFC24242418;  78: glyph_columns = 40'h18242418FC;
            79: glyph_columns = 40'h7C08040408;  80: glyph_columns = 40'h4854545420;
            81: glyph_columns = 40'h043F444020;  82: glyph_columns = 40'h3C4040207C;
            83: glyph_columns = 40'h1C2040201C;  84: glyph_columns = 40'h3C4030403C;
            85: glyph_columns = 40'h4428102844;  86: glyph_columns = 40'h0C5050503E;
            87: glyph_columns = 40'h4464544C44;  88: glyph_columns = 40'h08082A1C08;
            // space and the blank tail of the font
            default: glyph_columns = 40'h0;
        endcase
    endfunction

    function automatic void paint_pixel(input int col, input int row, input logic [31:0] color);
        frame_colors[row * FRAME_WIDTH + col]  = color;
        frame_written[row * FRAME_WIDTH + col] = 1'b1;
    endfunction

    // Apply one command to the local frame and return the result it must produce
    function automatic draw_result_t predict_draw_op(input draw_cmd_t cmd);
        draw_result_t res;
        int           x0, y0, w, h, n;
        logic [39:0]  cols;
        logic [7:0]   col_bits;
        res = '0;
        x0  = $signed(cmd.x_pos);
        y0  = $signed(cmd.y_pos);
        w   = $signed(cmd.rect_width);
        h   = $signed(cmd.rect_height);
        n   = 0;
        case (cmd.op)
            OP_FILL: begin
                // clip left/top by the overhang, then right/bottom at the frame edge
                if (x0 < 0) begin
                    w  = w + x0;
                    x0 = 0;
                end
                if (y0 < 0) begin
                    h  = h + y0;
                    y0 = 0;
                end
                if (x0 + w > FRAME_WIDTH)  w = FRAME_WIDTH - x0;
                if (y0 + h > FRAME_HEIGHT) h = FRAME_HEIGHT - y0;
                if (w > 0 && h > 0) begin
                    for (int r = y0; r < y0 + h; r++)
                        for (int c = x0; c < x0 + w; c++)
                            paint_pixel(c, r, cmd.color);
                    res.pixels_written = 14'(w * h);
                end
            end
            OP_GLYPH: begin
                // whole cell must be on the frame and the code printable
                if (cmd.char_code < FIRST_CODE || cmd.char_code > LAST_CODE || x0 < 0
                        || y0 < 0 || x0 + GLYPH_COLS > FRAME_WIDTH
                        || y0 + GLYPH_ROWS > FRAME_HEIGHT) begin
                    res.rejected = 1'b1;
                end else begin
                    cols = glyph_columns(int'(cmd.char_code) - int'(FIRST_CODE));
                    for (int c = 0; c < GLYPH_COLS; c++) begin
                        col_bits = cols[39 - 8 * c -: 8];
                        for (int r = 0; r < GLYPH_ROWS; r++)
                            if (col_bits[r]) begin
                                paint_pixel(x0 + c, y0 + r, cmd.color);
                                n++;
                            end
                    end
                    res.pixels_written = 14'(n);
                end
            end
            OP_READ: begin
                if (x0 < 0 || y0 < 0 || x0 >= FRAME_WIDTH || y0 >= FRAME_HEIGHT)
                    res.rejected = 1'b1;
                else
                    res.read_value = frame_colors[y0 * FRAME_WIDTH + x0];
            end
            default: ;  // unused op: all-zero result
        endcase
        return res;
    endfunction

    function automatic draw_cmd_t make_cmd(input op_t op, input int x, input int y,
                                           input int w, input int h,
                                           input logic [31:0] color, input int code);
        draw_cmd_t cmd;
        cmd.op          = op;
        cmd.x_pos       = 16'(x);
        cmd.y_pos       = 16'(y);
        cmd.rect_width  = 16'(w);
        cmd.rect_height = 16'(h);
        cmd.color       = color;
        cmd.char_code   = 8'(code);
        return cmd;
    endfunction

    function automatic void report_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    // Offer one command, wait for its transfer, then idle per the burst pattern
    task automatic send_draw_cmd(input draw_cmd_t cmd);
        int gap;
        s_tdata  <= {cmd.char_code, cmd.color, cmd.rect_height, cmd.rect_width,
                     cmd.y_pos, cmd.x_pos};
        s_tuser  <= cmd.op;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_draw_results.push_back(predict_draw_op(cmd));
        if (burst_left > 0 || !sender_gaps_on) begin
            if (burst_left > 0) burst_left--;
        end else begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 8);
        end
    endtask

    // Result checker
    always @(posedge aclk) begin
        draw_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.read_value     = m_tdata[31:0];
            got.pixels_written = m_tdata[45:32];
            got.rejected       = m_tuser;
            if (pending_draw_results.size() == 0) begin
                report_failure($sformatf("result with none pending: value %h count %0d rej %b",
                                         got.read_value, got.pixels_written, got.rejected));
            end else begin
                want = pending_draw_results.pop_front();
                if (got !== want || m_tdata[47:46] !== 2'b00)
                    report_failure($sformatf(
                        "exp value %h count %0d rej %b, got value %h count %0d rej %b pad %b",
                        want.read_value, want.pixels_written, want.rejected,
                        got.read_value, got.pixels_written, got.rejected, m_tdata[47:46]));
            end
        end
    end

    // Receiver: changing stall patterns, plus a counted hold-off on request
    initial begin
        ready_pattern_t pattern;
        int             span, tick;
        m_tready = 1'b0;
        pattern  = READY_ALWAYS;
        span     = 0;
        tick     = 0;
        forever begin
            @(posedge aclk);
            tick++;
            if (span == 0) begin
                pattern = ready_pattern_t'($urandom_range(0, 3));
                span    = $urandom_range(16, 96);
            end
            span--;
            if (hold_off_left > 0) begin
                hold_off_left--;
                m_tready <= 1'b0;
            end else begin
                case (pattern)
                    READY_ALWAYS: m_tready <= 1'b1;
                    READY_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    READY_SPARSE: m_tready <= (tick % 5 == 0);
                    default:      m_tready <= (tick % 7 < 4);
                endcase
            end
        end
    end

    // Fill: whole frame first (every pixel defined from here on), then clipping cases
    task automatic test_fill_clipping();
        send_draw_cmd(make_cmd(OP_FILL, 0, 0, FRAME_WIDTH, FRAME_HEIGHT, 32'h1234_5678, 0));
        send_draw_cmd(make_cmd(OP_FILL, -3, -2, 10, 5, 32'hFFFF_FFFF, 255));
        send_draw_cmd(make_cmd(OP_FILL, 120, 60, 32767, 32767, 32'hA5A5_0F0F, 0));
        send_draw_cmd(make_cmd(OP_FILL, 127, 63, 1, 1, 32'h0000_0001, 0));
        send_draw_cmd(make_cmd(OP_FILL, -32768, -32768, 32767, 32767, 32'hDEAD_BEEF, 0));
        send_draw_cmd(make_cmd(OP_FILL, 32767, 32767, 32767, 32767, 32'hDEAD_BEEF, 0));
        send_draw_cmd(make_cmd(OP_FILL, 5, 5, 0, 9, 32'hDEAD_BEEF, 0));
        send_draw_cmd(make_cmd(OP_FILL, 5, 5, -32768, -32768, 32'hDEAD_BEEF, 0));
    endtask

    // Glyph: blank, printable, bit 7 set, unprintable codes, cell off left, right and bottom edges
    task automatic test_glyph_draw();
        send_draw_cmd(make_cmd(OP_GLYPH, 0, 0, 0, 0, 32'h0000_00FF, 32));
        send_draw_cmd(make_cmd(OP_GLYPH, 123, 57, 0, 0, 32'h00FF_0000, 65));
        send_draw_cmd(make_cmd(OP_GLYPH, 123, 50, 0, 0, 32'h00FF_0000, 126));
        send_draw_cmd(make_cmd(OP_GLYPH, 60, 30, -1, -1, 32'h8000_0000, 46));
        send_draw_cmd(make_cmd(OP_GLYPH, 0, 57, 0, 0, 32'h0F0F_0F0F, 109));
        send_draw_cmd(make_cmd(OP_GLYPH, 10, 10, 0, 0, 32'h1111_1111, 31));
        send_draw_cmd(make_cmd(OP_GLYPH, 10, 10, 0, 0, 32'h1111_1111, 127));
        send_draw_cmd(make_cmd(OP_GLYPH, 10, 10, 0, 0, 32'h1111_1111, 255));
        send_draw_cmd(make_cmd(OP_GLYPH, 124, 57, 0, 0, 32'h2222_2222, 66));
        send_draw_cmd(make_cmd(OP_GLYPH, 123, 58, 0, 0, 32'h2222_2222, 66));
        send_draw_cmd(make_cmd(OP_GLYPH, -1, 0, 0, 0, 32'h2222_2222, 66));
        send_draw_cmd(make_cmd(OP_GLYPH, -32768, 32767, 0, 0, 32'h2222_2222, 66));
    endtask

    // Read: corners, glyph pixels, and out-of-frame coordinates
    task automatic test_pixel_read();
        send_draw_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0));
        send_draw_cmd(make_cmd(OP_READ, 127, 63, -1, -1, 32'hFFFF_FFFF, 255));
        send_draw_cmd(make_cmd(OP_READ, 123, 57, 0, 0, 0, 0));
        send_draw_cmd(make_cmd(OP_READ, 124, 58, 0, 0, 0, 0));
        send_draw_cmd(make_cmd(OP_READ, 128, 0, 0, 0, 0, 0));
        send_draw_cmd(make_cmd(OP_READ, 0, 64, 0, 0, 0, 0));
        send_draw_cmd(make_cmd(OP_READ, -32768, -32768, 0, 0, 0, 0));
        send_draw_cmd(make_cmd(OP_READ, 32767, 32767, 0, 0, 0, 0));
    endtask

    // Unused op returns all zeros whatever the fields hold
    task automatic test_unused_op();
        send_draw_cmd(make_cmd(OP_NONE, -1, -1, -1, -1, 32'hFFFF_FFFF, 255));
        send_draw_cmd(make_cmd(OP_NONE, 3, 3, 4, 4, 32'h5555_AAAA, 65));
    endtask

    // Long receiver hold-off while the sender keeps offering back to back
    task automatic test_output_backpressure();
        sender_gaps_on = 1'b0;
        hold_off_left  = 400;
        for (int i = 0; i < 24; i++) begin
            if (i % 3 == 0)
                send_draw_cmd(make_cmd(OP_GLYPH, $urandom_range(0, 123), $urandom_range(0, 57),
                                       0, 0, $urandom, $urandom_range(32, 126)));
            else
                send_draw_cmd(make_cmd(OP_READ, $urandom_range(0, 127), $urandom_range(0, 63),
                                       $urandom, $urandom, $urandom, $urandom));
        end
        sender_gaps_on = 1'b1;
    endtask

    // Random mix: mostly near-frame coordinates, some full-range, few large fills
    task automatic test_random_mix(input int count);
        draw_cmd_t cmd;
        int        sel, x, y;
        for (int i = 0; i < count; i++) begin
            sel             = $urandom_range(0, 99);
            cmd.x_pos       = 16'($urandom);
            cmd.y_pos       = 16'($urandom);
            cmd.rect_width  = 16'($urandom);
            cmd.rect_height = 16'($urandom);
            cmd.color       = $urandom;
            cmd.char_code   = 8'($urandom);
            if (sel < 35) begin
                cmd.op = OP_FILL;
                if ($urandom_range(0, 9) != 0) begin
                    cmd.x_pos = 16'($urandom_range(0, 150) - 12);
                    cmd.y_pos = 16'($urandom_range(0, 86) - 12);
                end
                if ($urandom_range(0, 29) != 0) begin
                    cmd.rect_width  = 16'($urandom_range(0, 20) - 4);
                    cmd.rect_height = 16'($urandom_range(0, 20) - 4);
                end
            end else if (sel < 70) begin
                cmd.op = OP_GLYPH;
                if ($urandom_range(0, 9) != 0) begin
                    cmd.x_pos = 16'($urandom_range(0, 130) - 3);
                    cmd.y_pos = 16'($urandom_range(0, 66) - 3);
                end
                if ($urandom_range(0, 4) != 0)
                    cmd.char_code = 8'($urandom_range(32, 126));
            end else if (sel < 95) begin
                cmd.op = OP_READ;
                if ($urandom_range(0, 4) != 0) begin
                    cmd.x_pos = 16'($urandom_range(0, 129) - 1);
                    cmd.y_pos = 16'($urandom_range(0, 65) - 1);
                end
                // never address a pixel that has not been written
                x = $signed(cmd.x_pos);
                y = $signed(cmd.y_pos);
                if (x >= 0 && y >= 0 && x < FRAME_WIDTH && y < FRAME_HEIGHT
                        && !frame_written[y * FRAME_WIDTH + x])
                    cmd.x_pos = 16'(-1);
            end else begin
                cmd.op = OP_NONE;
            end
            send_draw_cmd(cmd);
        end
    endtask

    // Main sequence
    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_FILL;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_fill_clipping();
        test_glyph_draw();
        test_pixel_read();
        test_unused_op();
        test_output_backpressure();
        test_random_mix(390);

        // drain and let the pipeline settle
        s_tvalid <= 1'b0;
        while (pending_draw_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (mismatch_count == 0 && pending_draw_results.size() == 0) begin
            $display("clipped_rect_and_glyph_draw_unit test passed");
        end else begin
            $display("clipped_rect_and_glyph_draw_unit test failed");
        end
        $finish;
    end

endmodule
